// ===== src/sfx_pkg.sv =====
// ---------------------------------------------------------------------------
// sfx_pkg
// Shared types, codes and helpers for the framed SPI exchange block.
// ---------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

	typedef enum logic [2:0] {
		M_PAIR  = 3'd0,
		M_BLOCK = 3'd1,
		M_START = 3'd2,
		M_LINK  = 3'd3,
		M_READ  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SYNC  = 3'd1,
		PH_LEN   = 3'd2,
		PH_SWAP  = 3'd3,
		PH_COUNT = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CS_IDLE  = 2'd0,
		CS_EXEC  = 2'd1,
		CS_PAIR2 = 2'd2
	} ctrl_state_t;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] PAD_BYTE  = 8'h00;
	localparam logic [7:0] POP_M1    = 8'h55;
	localparam logic [7:0] POP_M2    = 8'h33;
	localparam logic [7:0] POP_M4    = 8'h0F;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] cmd_byte;
		logic [7:0] data_byte;
		logic [7:0] block_size;
		logic       block_first;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       done_res;
		logic       check_ok;
		logic [7:0] rx_length;
		logic [7:0] read_byte;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic second;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_valid;
		logic pair_second;
	} dp_status_t;

	function automatic logic [7:0] bits_set(input logic [7:0] v);
		logic [7:0] x;
		x = v - ((v >> 1) & POP_M1);
		x = (x & POP_M2) + ((x >> 2) & POP_M2);
		x = (x + (x >> 4)) & POP_M4;
		return x;
	endfunction

endpackage

`default_nettype wire

// ===== src/sfx_stream_if.sv =====
// ---------------------------------------------------------------------------
// sfx_stream_if
// Valid/ready channel carrying one payload word per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfx_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/sfx_ram.sv =====
// ---------------------------------------------------------------------------
// sfx_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sfx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

`default_nettype wire

// ===== src/sfx_ctrl.sv =====
// ---------------------------------------------------------------------------
// sfx_ctrl
// Sequencer: accept, execute, and an extra write state for command pairs.
// ---------------------------------------------------------------------------
`default_nettype none

module sfx_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic                out_ready,
	input  wire sfx_pkg::dp_status_t status,
	output      sfx_pkg::ctrl_cmd_t  cmd
);
	sfx_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfx_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sfx_pkg::CS_IDLE: begin
				// output slot must be empty by the time the result is loaded
				in_ready = !status.out_valid || out_ready;
				if (in_valid && in_ready) begin
					cmd.capture = 1'b1;
					state_d     = sfx_pkg::CS_EXEC;
				end
			end
			sfx_pkg::CS_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.pair_second ? sfx_pkg::CS_PAIR2 : sfx_pkg::CS_IDLE;
			end
			sfx_pkg::CS_PAIR2: begin
				cmd.second = 1'b1;
				state_d    = sfx_pkg::CS_IDLE;
			end
			default: begin
				state_d = sfx_pkg::CS_IDLE;
			end
		endcase
	end
endmodule

`default_nettype wire

// ===== src/sfx_datapath.sv =====
// ---------------------------------------------------------------------------
// sfx_datapath
// Queue counters, exchange phase, popcount sum, buffers and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sfx_datapath #(
	parameter int BUF_DEPTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfx_pkg::ctrl_cmd_t  cmd,
	output      sfx_pkg::dp_status_t status,
	input  wire sfx_pkg::in_item_t   in_item,
	input  wire logic                out_ready,
	output      logic                out_valid,
	output      sfx_pkg::out_item_t  out_item
);
	localparam int         AW      = $clog2(BUF_DEPTH);
	localparam logic [7:0] DEPTH_B = 8'(BUF_DEPTH);

	// latched request
	logic [2:0] mode_q;
	logic [7:0] cmd_q, data_q, bsize_q, ridx_q;
	logic       bfirst_q;

	// exchange state
	sfx_pkg::phase_t phase_q, phase_d;
	logic [7:0] tx_count_q, tx_count_d;
	logic [7:0] rx_count_q, rx_count_d;
	logic [7:0] byte_index_q, byte_index_d;
	logic [7:0] swap_total_q, swap_total_d;
	logic [7:0] ones_sum_q, ones_sum_d;
	logic [7:0] block_left_q, block_left_d;
	logic       out_valid_q;
	logic       pair_second;
	sfx_pkg::out_item_t res_d;

	// buffer ports
	logic          tx_we, rx_we;
	logic [7:0]    tx_wdata;
	logic [AW-1:0] tx_raddr, rx_raddr;
	logic [7:0]    tx_rdata, rx_rdata;

	logic [7:0] nxt_idx, swap_max, dat_pop;
	logic [8:0] room;
	logic       tx_has_room;

	assign nxt_idx     = byte_index_q + 8'd1;
	assign room        = {1'b0, DEPTH_B} - {1'b0, tx_count_q};
	assign tx_has_room = tx_count_q < DEPTH_B;
	assign swap_max    = (data_q > tx_count_q) ? data_q : tx_count_q;
	assign dat_pop     = sfx_pkg::bits_set(data_q);

	// reads are issued in the accept cycle; data lands for the execute cycle
	assign tx_raddr = (phase_q == sfx_pkg::PH_LEN) ? '0 : nxt_idx[AW-1:0];
	assign rx_raddr = in_item.read_index[AW-1:0];

	sfx_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_we),
		.wr_addr (tx_count_q[AW-1:0]),
		.wr_data (tx_wdata),
		.rd_addr (tx_raddr),
		.rd_data (tx_rdata)
	);

	sfx_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_we),
		.wr_addr (byte_index_q[AW-1:0]),
		.wr_data (data_q),
		.rd_addr (rx_raddr),
		.rd_data (rx_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= in_item.mode;
			cmd_q    <= in_item.cmd_byte;
			data_q   <= in_item.data_byte;
			bsize_q  <= in_item.block_size;
			bfirst_q <= in_item.block_first;
			ridx_q   <= in_item.read_index;
		end
		if (cmd.exec) begin
			out_item <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sfx_pkg::PH_IDLE;
			tx_count_q   <= '0;
			rx_count_q   <= '0;
			byte_index_q <= '0;
			swap_total_q <= '0;
			ones_sum_q   <= '0;
			block_left_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			tx_count_q   <= tx_count_d;
			rx_count_q   <= rx_count_d;
			byte_index_q <= byte_index_d;
			swap_total_q <= swap_total_d;
			ones_sum_q   <= ones_sum_d;
			block_left_q <= block_left_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		phase_d      = phase_q;
		tx_count_d   = tx_count_q;
		rx_count_d   = rx_count_q;
		byte_index_d = byte_index_q;
		swap_total_d = swap_total_q;
		ones_sum_d   = ones_sum_q;
		block_left_d = block_left_q;
		tx_we        = 1'b0;
		tx_wdata     = data_q;
		rx_we        = 1'b0;
		res_d        = '0;
		pair_second  = 1'b0;

		if (cmd.second) begin
			// data half of a command pair
			if (tx_has_room) begin
				tx_we      = 1'b1;
				tx_count_d = tx_count_q + 8'd1;
			end
		end else if (cmd.exec) begin
			unique case (mode_q)
				sfx_pkg::M_PAIR: begin
					if (phase_q == sfx_pkg::PH_IDLE && room >= 9'd2) begin
						res_d.accepted = 1'b1;
						pair_second    = 1'b1;
						tx_wdata       = cmd_q;
						if (tx_has_room) begin
							tx_we      = 1'b1;
							tx_count_d = tx_count_q + 8'd1;
						end
					end
				end
				sfx_pkg::M_BLOCK: begin
					if (phase_q == sfx_pkg::PH_IDLE) begin
						if (bfirst_q) begin
							if (room >= {1'b0, bsize_q}) begin
								res_d.accepted = 1'b1;
								block_left_d   = '0;
								if (bsize_q != 8'd0) begin
									block_left_d = bsize_q - 8'd1;
									if (tx_has_room) begin
										tx_we      = 1'b1;
										tx_count_d = tx_count_q + 8'd1;
									end
								end
							end
						end else if (block_left_q != 8'd0) begin
							res_d.accepted = 1'b1;
							block_left_d   = block_left_q - 8'd1;
							if (tx_has_room) begin
								tx_we      = 1'b1;
								tx_count_d = tx_count_q + 8'd1;
							end
						end
					end
				end
				sfx_pkg::M_START: begin
					if (phase_q == sfx_pkg::PH_IDLE) begin
						phase_d          = sfx_pkg::PH_SYNC;
						res_d.send_valid = 1'b1;
						res_d.send_byte  = sfx_pkg::SYNC_BYTE;
					end
				end
				sfx_pkg::M_LINK: begin
					unique case (phase_q)
						sfx_pkg::PH_SYNC: begin
							phase_d          = sfx_pkg::PH_LEN;
							res_d.send_valid = 1'b1;
							res_d.send_byte  = tx_count_q;
						end
						sfx_pkg::PH_LEN: begin
							ones_sum_d       = dat_pop;
							swap_total_d     = swap_max;
							rx_count_d       = (data_q < DEPTH_B) ? data_q : DEPTH_B;
							byte_index_d     = '0;
							res_d.send_valid = 1'b1;
							if (swap_max != 8'd0) begin
								phase_d = sfx_pkg::PH_SWAP;
								res_d.send_byte = (tx_count_q != 8'd0) ? tx_rdata
									: sfx_pkg::PAD_BYTE;
							end else begin
								phase_d         = sfx_pkg::PH_COUNT;
								res_d.send_byte = sfx_pkg::PAD_BYTE;
							end
						end
						sfx_pkg::PH_SWAP: begin
							// keep only what fits in the receive buffer
							if (byte_index_q < rx_count_q) begin
								rx_we      = 1'b1;
								ones_sum_d = ones_sum_q + dat_pop;
							end
							byte_index_d     = nxt_idx;
							res_d.send_valid = 1'b1;
							if (nxt_idx < swap_total_q) begin
								res_d.send_byte = (nxt_idx < tx_count_q) ? tx_rdata
									: sfx_pkg::PAD_BYTE;
							end else begin
								phase_d         = sfx_pkg::PH_COUNT;
								res_d.send_byte = sfx_pkg::PAD_BYTE;
							end
						end
						sfx_pkg::PH_COUNT: begin
							res_d.check_ok = (data_q == ones_sum_q);
							if (data_q != ones_sum_q) begin
								rx_count_d = '0;
							end
							tx_count_d     = '0;
							block_left_d   = '0;
							phase_d        = sfx_pkg::PH_IDLE;
							res_d.done_res = 1'b1;
						end
						default: begin
							// link byte while idle is dropped
						end
					endcase
				end
				sfx_pkg::M_READ: begin
					if (phase_q == sfx_pkg::PH_IDLE && ridx_q < rx_count_q) begin
						res_d.read_byte = rx_rdata;
					end
				end
				default: begin
				end
			endcase
			res_d.rx_length = rx_count_d;
		end
	end

	assign status    = '{out_valid: out_valid_q, pair_second: pair_second};
	assign out_valid = out_valid_q;
endmodule

`default_nettype wire

// ===== src/spi_frame_exchange_popcount_check.sv =====
// ---------------------------------------------------------------------------
// spi_frame_exchange_popcount_check
// Master side of a framed full-duplex byte exchange with popcount check.
//
//   channel  dir  payload     transfer
//   item     in   in_item_t   valid & ready
//   result   out  out_item_t  valid & ready
//
// Every item yields one result. A request is accepted, then executed against
// the registered buffer read; a queued command pair then passes through
// CS_PAIR2 for its second buffer write, as the transmit RAM has one write port.
// The result register frees the input side: a new item is taken in the cycle
// the previous result is transferred. Reset clears counters and phase; the
// buffers are not cleared and need no sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module spi_frame_exchange_popcount_check #(
	parameter int BUF_DEPTH = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sfx_stream_if.sink   item,
	sfx_stream_if.source result
);
	sfx_pkg::ctrl_cmd_t  cmd;
	sfx_pkg::dp_status_t status;
	sfx_pkg::in_item_t   in_item;
	sfx_pkg::out_item_t  out_item;

	assign in_item        = item.payload;
	assign result.payload = out_item;

	sfx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sfx_datapath #(.BUF_DEPTH(BUF_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (in_item),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_item  (out_item)
	);
endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for spi_frame_exchange_popcount_check. A software copy
// of the block's queue, framing and bit-count logic predicts one result per
// transfer. The stimulus is directed corner cases first, then random frames
// with noise, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH        = 32;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 520;
	localparam int IDLE_PCT     = 18;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 20;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int REPORT_LIMIT = 10;
	localparam int TIMEOUT_NS   = 5_000_000;

	// mode codes with no function
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	sfx_stream_if #(.payload_t(sfx_pkg::in_item_t))  item_if ();
	sfx_stream_if #(.payload_t(sfx_pkg::out_item_t)) result_if ();

	spi_frame_exchange_popcount_check #(.BUF_DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// ------------------------------------------------------------------
	// Exchange predictor state
	// ------------------------------------------------------------------
	logic [7:0] tx_bytes [DEPTH];
	logic [7:0] rx_bytes [DEPTH];
	logic [7:0] tx_len;
	logic [7:0] rx_len;
	logic [7:0] swap_pos;
	logic [7:0] swap_len;
	logic [7:0] ones_acc;
	logic [7:0] block_rem;
	sfx_pkg::phase_t link_phase;

	sfx_pkg::out_item_t expected_q [$];
	int        items_sent = 0;
	int        mismatches = 0;
	bit        idle_on = 1'b1;
	bit        hold_req = 1'b0;
	int        hold_left = 0;

	function automatic void queue_byte(input logic [7:0] b);
		if (tx_len < DEPTH) begin
			tx_bytes[tx_len] = b;
			tx_len = tx_len + 8'd1;
		end
	endfunction

	function automatic logic [7:0] queued_byte(input logic [7:0] i);
		return (i < tx_len && i < DEPTH) ? tx_bytes[i] : sfx_pkg::PAD_BYTE;
	endfunction

	function automatic sfx_pkg::out_item_t predict_exchange(input sfx_pkg::in_item_t it);
		sfx_pkg::out_item_t r;
		int room;
		logic [7:0] d;
		r = '0;
		room = DEPTH - int'(tx_len);
		d = it.data_byte;
		case (it.mode)
			sfx_pkg::M_PAIR: begin
				if (link_phase == sfx_pkg::PH_IDLE && room >= 2) begin
					queue_byte(it.cmd_byte);
					queue_byte(d);
					r.accepted = 1'b1;
				end
			end
			sfx_pkg::M_BLOCK: begin
				if (link_phase == sfx_pkg::PH_IDLE) begin
					if (it.block_first) begin
						// all-or-nothing: the whole block must fit
						if (room >= int'(it.block_size)) begin
							r.accepted = 1'b1;
							block_rem = 8'd0;
							if (it.block_size != 8'd0) begin
								queue_byte(d);
								block_rem = it.block_size - 8'd1;
							end
						end
					end else if (block_rem != 8'd0) begin
						queue_byte(d);
						block_rem = block_rem - 8'd1;
						r.accepted = 1'b1;
					end
				end
			end
			sfx_pkg::M_START: begin
				if (link_phase == sfx_pkg::PH_IDLE) begin
					link_phase = sfx_pkg::PH_SYNC;
					r.send_valid = 1'b1;
					r.send_byte = sfx_pkg::SYNC_BYTE;
				end
			end
			sfx_pkg::M_LINK: begin
				case (link_phase)
					sfx_pkg::PH_SYNC: begin
						link_phase = sfx_pkg::PH_LEN;
						r.send_valid = 1'b1;
						r.send_byte = tx_len;
					end
					sfx_pkg::PH_LEN: begin
						ones_acc = 8'($countones(d));
						swap_len = (d > tx_len) ? d : tx_len;
						rx_len = (d < DEPTH) ? d : 8'(DEPTH);
						swap_pos = 8'd0;
						r.send_valid = 1'b1;
						if (swap_len != 8'd0) begin
							link_phase = sfx_pkg::PH_SWAP;
							r.send_byte = queued_byte(8'd0);
						end else begin
							link_phase = sfx_pkg::PH_COUNT;
							r.send_byte = sfx_pkg::PAD_BYTE;
						end
					end
					sfx_pkg::PH_SWAP: begin
						if (swap_pos < rx_len && swap_pos < DEPTH) begin
							rx_bytes[swap_pos] = d;
							ones_acc = ones_acc + 8'($countones(d));
						end
						swap_pos = swap_pos + 8'd1;
						r.send_valid = 1'b1;
						if (swap_pos < swap_len) begin
							r.send_byte = queued_byte(swap_pos);
						end else begin
							link_phase = sfx_pkg::PH_COUNT;
							r.send_byte = sfx_pkg::PAD_BYTE;
						end
					end
					sfx_pkg::PH_COUNT: begin
						r.check_ok = (d == ones_acc);
						if (!r.check_ok)
							rx_len = 8'd0;
						tx_len = 8'd0;
						block_rem = 8'd0;
						link_phase = sfx_pkg::PH_IDLE;
						r.done_res = 1'b1;
					end
					default: ;
				endcase
			end
			sfx_pkg::M_READ: begin
				if (link_phase == sfx_pkg::PH_IDLE && it.read_index < rx_len
						&& it.read_index < DEPTH)
					r.read_byte = rx_bytes[it.read_index];
			end
			default: ;
		endcase
		r.rx_length = rx_len;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Item sender
	// ------------------------------------------------------------------
	function automatic sfx_pkg::in_item_t make_item(input logic [2:0] m);
		sfx_pkg::in_item_t it;
		it.mode        = m;
		it.cmd_byte    = 8'($urandom);
		it.data_byte   = 8'($urandom);
		it.block_size  = 8'($urandom);
		it.block_first = 1'($urandom);
		it.read_index  = 8'($urandom);
		return it;
	endfunction

	// valid stays high from one transfer to the next unless a gap is taken
	task automatic send_item(input sfx_pkg::in_item_t it);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.payload <= it;
		do @(posedge clk); while (!item_if.ready);
		expected_q.push_back(predict_exchange(it));
		items_sent++;
	endtask

	task automatic send_noise();
		send_item(make_item(3'($urandom_range(7))));
	endtask

	task automatic send_mode(input logic [2:0] m);
		send_item(make_item(m));
	endtask

	task automatic link(input logic [7:0] d);
		sfx_pkg::in_item_t it;
		it = make_item(sfx_pkg::M_LINK);
		it.data_byte = d;
		send_item(it);
	endtask

	task automatic read_at(input logic [7:0] idx);
		sfx_pkg::in_item_t it;
		it = make_item(sfx_pkg::M_READ);
		it.read_index = idx;
		send_item(it);
	endtask

	task automatic pair(input logic [7:0] c, input logic [7:0] d);
		sfx_pkg::in_item_t it;
		it = make_item(sfx_pkg::M_PAIR);
		it.cmd_byte = c;
		it.data_byte = d;
		send_item(it);
	endtask

	task automatic block_byte(input logic first, input logic [7:0] size, input logic [7:0] d);
		sfx_pkg::in_item_t it;
		it = make_item(sfx_pkg::M_BLOCK);
		it.block_first = first;
		it.block_size = size;
		it.data_byte = d;
		send_item(it);
	endtask

	// drives link bytes until the exchange under way has finished
	task automatic link_frame(input logic [7:0] peer_len, input bit count_good,
			input int noise_pct);
		while (link_phase != sfx_pkg::PH_IDLE) begin
			if ($urandom_range(99) < noise_pct) begin
				send_noise();
			end else begin
				case (link_phase)
					sfx_pkg::PH_LEN:   link(peer_len);
					sfx_pkg::PH_COUNT: link(count_good ? ones_acc
						: ones_acc ^ 8'($urandom_range(255, 1)));
					default:           link(8'($urandom));
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: ready generation and checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_result
		sfx_pkg::out_item_t want;
		sfx_pkg::out_item_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.payload;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				check_field("accepted",   8'(want.accepted),   8'(got.accepted));
				check_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
				check_field("send_byte",  want.send_byte,      got.send_byte);
				check_field("done_res",   8'(want.done_res),   8'(got.done_res));
				check_field("check_ok",   8'(want.check_ok),   8'(got.check_ok));
				check_field("rx_length",  want.rx_length,      got.rx_length);
				check_field("read_byte",  want.read_byte,      got.read_byte);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_idle_corners();
		read_at(8'h00);
		read_at(8'hFF);
		send_mode(MODE_SPARE_LO);
		send_mode(MODE_SPARE_HI);
		link(8'hA5);
	endtask

	// empty queue and zero peer length go straight to the count byte
	task automatic test_empty_exchange();
		send_mode(sfx_pkg::M_START);
		link_frame(8'h00, 1'b0, 0);
	endtask

	task automatic test_block_queue();
		block_byte(1'b0, 8'd5, 8'h11);
		block_byte(1'b1, 8'd0, 8'h22);
		block_byte(1'b1, 8'd3, 8'h00);
		block_byte(1'b0, 8'd0, 8'hFF);
		block_byte(1'b1, 8'd2, 8'h5A);
		block_byte(1'b0, 8'd9, 8'hC3);
		block_byte(1'b0, 8'd1, 8'h3C);
		block_byte(1'b1, 8'd255, 8'h77);
	endtask

	task automatic test_pair_queue();
		pair(8'h00, 8'hFF);
		pair(8'hFF, 8'h00);
	endtask

	task automatic test_exchange_busy();
		send_mode(sfx_pkg::M_START);
		pair(8'h12, 8'h34);
		block_byte(1'b1, 8'd1, 8'h56);
		send_mode(sfx_pkg::M_START);
		read_at(8'h00);
		link_frame(8'd2, 1'b1, 0);
		read_at(8'd0);
		read_at(8'd1);
		read_at(8'd2);
		read_at(8'hFF);
	endtask

	task automatic test_random_frames();
		int base;
		int n_req;
		int r;
		logic [7:0] peer_len;
		logic [7:0] bsize;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			idle_on = !((items_sent - base) >= 250 && (items_sent - base) < 400);
			n_req = $urandom_range(0, 18);
			for (int i = 0; i < n_req; i++) begin
				r = $urandom_range(99);
				if (r < 8) begin
					send_noise();
				end else if (r < 55) begin
					pair(8'($urandom), 8'($urandom));
				end else begin
					r = $urandom_range(99);
					if (r < 10)
						bsize = 8'd0;
					else if (r < 85)
						bsize = 8'($urandom_range(1, 8));
					else
						bsize = 8'($urandom_range(9, 255));
					block_byte(1'b1, bsize, 8'($urandom));
					// occasionally cut a block short so the next first byte restarts it
					while (block_rem != 8'd0 && $urandom_range(99) >= 8)
						block_byte(1'b0, 8'($urandom), 8'($urandom));
				end
			end
			send_mode(sfx_pkg::M_START);
			r = $urandom_range(99);
			if (r < 77)
				peer_len = 8'($urandom_range(0, 20));
			else if (r < 92)
				peer_len = 8'($urandom_range(21, 40));
			else
				peer_len = 8'($urandom_range(41, 255));
			link_frame(peer_len, $urandom_range(99) < 80, 6);
			repeat ($urandom_range(0, 4))
				read_at(8'($urandom_range(0, int'(rx_len) + 2)));
		end
		idle_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_stall();
		hold_req = 1'b1;
		repeat (30) begin
			if ($urandom_range(1))
				read_at(8'($urandom_range(0, DEPTH)));
			else
				pair(8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int drain;
		item_if.valid = 1'b0;
		item_if.payload = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tx_bytes[i] = 8'd0;
			rx_bytes[i] = 8'd0;
		end
		tx_len = 8'd0;
		rx_len = 8'd0;
		swap_pos = 8'd0;
		swap_len = 8'd0;
		ones_acc = 8'd0;
		block_rem = 8'd0;
		link_phase = sfx_pkg::PH_IDLE;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_corners();
		test_empty_exchange();
		test_block_queue();
		test_pair_queue();
		test_exchange_busy();
		test_random_frames();
		test_output_stall();
		item_if.valid <= 1'b0;

		drain = 0;
		while (expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			$display("%0d results never arrived", expected_q.size());

		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
